FILE: rtl/core/plht_pkg.sv
// Package for the polygon layer hit test: sizes, scale constants,
// command codes and the item, result and queue status structs. No dependencies.
package plht_pkg;

	localparam int MAX_LAYERS = 16;
	localparam int MAX_POINTS = 256;
	localparam int MIN_VERTS  = 3;

	localparam int LW = $clog2(MAX_LAYERS);     // layer index bits
	localparam int PW = $clog2(MAX_POINTS);     // vertex index bits
	localparam int AW = LW + PW;                // vertex store address bits
	localparam int CW = $clog2(MAX_LAYERS + 1); // layer count bits
	localparam int NW = $clog2(MAX_POINTS + 1); // vertex count bits

	// 256 * 200 and 256 * 400, the body-space scale of x and y
	localparam logic signed [17:0] X_SCALE = 18'sd51200;
	localparam logic signed [17:0] Y_SCALE = 18'sd102400;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_OPEN   = 2'd1,
		CMD_APPEND = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [1:0]         view;
		logic signed [23:0] view_width;
		logic signed [23:0] view_height;
		logic signed [23:0] vertex_x;
		logic signed [23:0] vertex_y;
		logic signed [19:0] body_x;
		logic signed [19:0] body_y;
	} item_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] hit_layer;
	} result_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic empty;
		logic full;
	} q_stat_t;

endpackage

FILE: rtl/core/polygon_layer_hit_test.sv
// Top level of the polygon layer hit test: front queue plus back engine.
// Depends on plht_pkg, plht_front and plht_back.
//
//  channel | ports                   | handshake
//  --------+-------------------------+-------------------------------------
//  item    | start, busy, item       | taken at an edge with start && !busy
//  result  | done, result            | done high one cycle, cannot stall
//
// Clear, open and append are each handled by the back end in its idle state.
// A query scans the layers in order, skipping ineligible ones; each eligible
// layer reads its n vertices through the single vertex store read port,
// feeding one edge a cycle, then drains the edge pipeline; the first layer
// that hits ends the query. Reset clears the layer count and the queue; the
// vertex store needs no clearing. busy rises only when the two-entry queue
// is full; results are never held back.
module polygon_layer_hit_test import plht_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	item_t   head;
	logic    pop;
	q_stat_t qstat;

	// accept and queue items
	plht_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.pop    (pop),
		.head   (head),
		.stat   (qstat)
	);

	// execute items in order
	plht_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!qstat.empty),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.result     (result)
	);

	// never pop an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.pop |-> !qstat.empty)
		else $error("queue popped while empty");

	// a miss reports layer zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> result.hit_layer == 4'd0)
		else $error("miss with nonzero layer");

	// a query always returns to idle after its result, so results never come back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on consecutive cycles");

	// busy only when the queue is full and so nothing is pushed
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> qstat.full && !qstat.push)
		else $error("busy without a full queue");

endmodule

FILE: rtl/core/plht_front.sv
// Front end of the hit test: accepts items and holds them in a two-entry queue.
// Depends on plht_pkg.
module plht_front import plht_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	input  logic    pop,
	output item_t   head,
	output q_stat_t stat
);

	item_t      entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign head = entry_q[rd_q];

	assign stat.push  = push;
	assign stat.pop   = pop;
	assign stat.empty = (cnt_q == 2'd0);
	assign stat.full  = busy;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/plht_back.sv
// Back end of the hit test: layer table, vertex store and the edge pipeline
// that runs even-odd ray casting one edge per cycle. Depends on plht_pkg.
module plht_back import plht_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  item_t   head,
	output logic    pop,
	output logic    done,
	output result_t result
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_SETUP = 5'b00100,
		S_READ  = 5'b01000,
		S_DRAIN = 5'b10000
	} state_t;

	state_t state_q;

	// layer table
	logic [NW-1:0]      lay_pts_q [MAX_LAYERS];
	logic [1:0]         lay_view_q [MAX_LAYERS];
	logic signed [23:0] lay_w_q [MAX_LAYERS];
	logic signed [23:0] lay_h_q [MAX_LAYERS];
	logic [CW-1:0]      total_q;
	logic               open_q;
	logic [NW-1:0]      open_pts_q;

	logic [47:0] mem [MAX_LAYERS * MAX_POINTS];

	// query context
	logic [1:0]         qview_q;
	logic signed [19:0] bx_q;
	logic signed [19:0] by_q;
	logic [CW-1:0]      k_q;
	logic [NW-1:0]      n_q;
	logic [NW-1:0]      rd_q;
	logic signed [43:0] px_q;
	logic signed [43:0] py_q;
	logic               inside_q;
	logic               done_q;
	result_t            result_q;

	logic [LW-1:0] kidx;
	logic [LW-1:0] widx;
	logic [NW-1:0] ridx;
	logic [AW-1:0] raddr;
	logic          rd_en;
	logic          wr_en;
	logic          eligible;
	logic          pipe_busy;

	// edge pipeline
	logic               v1_s1, first_s1;
	logic [47:0]        rdata_s1;
	logic signed [23:0] cx, cy;
	logic signed [41:0] csx, csy;

	logic signed [23:0] prev_x_q, prev_y_q;
	logic signed [41:0] prev_sy_q;

	logic               v2_s2;
	logic signed [23:0] xi_s2, yi_s2, xj_s2, yj_s2;
	logic signed [41:0] sxi_s2, syi_s2, syj_s2;

	logic               v3_s3, cond_s3, dpos_s3;
	logic signed [44:0] a_s3, d_s3;
	logic signed [25:0] b_s3;
	logic signed [24:0] c_s3;

	logic               v4_s4, cond_s4, dpos_s4;
	logic signed [47:0] pah_s4;
	logic signed [49:0] pal_s4;
	logic signed [46:0] pdh_s4;
	logic signed [48:0] pdl_s4;

	logic               v5_s5, cond_s5, dpos_s5;
	logic signed [71:0] lhs_s5, rhs_s5;

	assign kidx  = k_q[LW-1:0];
	assign widx  = LW'(total_q - CW'(1));
	assign ridx  = (rd_q == '0) ? (n_q - NW'(1)) : (rd_q - NW'(1));
	assign raddr = {kidx, ridx[PW-1:0]};
	assign rd_en = (state_q == S_READ);
	assign wr_en = (state_q == S_IDLE) && head_valid && (head.cmd == CMD_APPEND)
		&& open_q && (open_pts_q < NW'(MAX_POINTS));

	assign eligible = (lay_view_q[kidx] == qview_q)
		&& (lay_pts_q[kidx] >= NW'(MIN_VERTS))
		&& (lay_w_q[kidx] > 24'sd0) && (lay_h_q[kidx] > 24'sd0);

	assign pipe_busy = v1_s1 || v2_s2 || v3_s3 || v4_s4 || v5_s5;

	assign pop    = (state_q == S_IDLE) && head_valid;
	assign done   = done_q;
	assign result = result_q;

	// vertex store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{widx, open_pts_q[PW-1:0]}] <= {head.vertex_x, head.vertex_y};
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// layer table payload
	always_ff @(posedge clk) begin
		if (pop && head.cmd == CMD_OPEN && total_q < CW'(MAX_LAYERS)) begin
			lay_pts_q[LW'(total_q)]  <= '0;
			lay_view_q[LW'(total_q)] <= head.view;
			lay_w_q[LW'(total_q)]    <= head.view_width;
			lay_h_q[LW'(total_q)]    <= head.view_height;
		end
		if (wr_en) begin
			lay_pts_q[widx] <= open_pts_q + NW'(1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			total_q    <= '0;
			open_q     <= 1'b0;
			open_pts_q <= '0;
			k_q        <= '0;
			rd_q       <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						case (head.cmd)
							CMD_CLEAR: begin
								total_q <= '0;
								open_q  <= 1'b0;
							end
							CMD_OPEN: begin
								if (total_q < CW'(MAX_LAYERS)) begin
									total_q    <= total_q + CW'(1);
									open_q     <= 1'b1;
									open_pts_q <= '0;
								end else begin
									open_q <= 1'b0;
								end
							end
							CMD_APPEND: begin
								if (wr_en) begin
									open_pts_q <= open_pts_q + NW'(1);
								end
							end
							CMD_QUERY: begin
								k_q     <= '0;
								state_q <= S_SCAN;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					if (k_q >= total_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (eligible) begin
						state_q <= S_SETUP;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_SETUP: begin
					rd_q    <= '0;
					state_q <= S_READ;
				end
				S_READ: begin
					rd_q <= rd_q + NW'(1);
					if (rd_q == n_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!pipe_busy) begin
						if (inside_q) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= S_SCAN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// query payload and result
	always_ff @(posedge clk) begin
		if (pop && head.cmd == CMD_QUERY) begin
			qview_q <= head.view;
			bx_q    <= head.body_x;
			by_q    <= head.body_y;
		end
		if (state_q == S_SETUP) begin
			px_q <= bx_q * lay_w_q[kidx];
			py_q <= by_q * lay_h_q[kidx];
			n_q  <= lay_pts_q[kidx];
		end
		if (state_q == S_SCAN && k_q >= total_q) begin
			result_q <= '{hit: 1'b0, hit_layer: 4'd0};
		end
		if (state_q == S_DRAIN && !pipe_busy && inside_q) begin
			result_q <= '{hit: 1'b1, hit_layer: 4'(k_q)};
		end
	end

	// pipeline valid bits and parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1    <= 1'b0;
			v2_s2    <= 1'b0;
			v3_s3    <= 1'b0;
			v4_s4    <= 1'b0;
			v5_s5    <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			v1_s1 <= rd_en;
			v2_s2 <= v1_s1 && !first_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
			if (state_q == S_SETUP) begin
				inside_q <= 1'b0;
			end else if (v5_s5 && cond_s5
				&& (dpos_s5 ? (lhs_s5 < rhs_s5) : (rhs_s5 < lhs_s5))) begin
				inside_q <= ~inside_q;
			end
		end
	end

	assign cx  = rdata_s1[47:24];
	assign cy  = rdata_s1[23:0];
	assign csx = cx * X_SCALE;
	assign csy = cy * Y_SCALE;

	// pipeline payload
	always_ff @(posedge clk) begin
		first_s1 <= (rd_q == '0);
		if (v1_s1) begin
			prev_x_q  <= cx;
			prev_y_q  <= cy;
			prev_sy_q <= csy;
			xi_s2     <= cx;
			yi_s2     <= cy;
			xj_s2     <= prev_x_q;
			yj_s2     <= prev_y_q;
			sxi_s2    <= csx;
			syi_s2    <= csy;
			syj_s2    <= prev_sy_q;
		end
		// edge terms: A = X - xi, D = Y - yi, B = 2 (yj - yi), C = xj - xi
		a_s3    <= 45'(px_q) - 45'(sxi_s2);
		d_s3    <= 45'(py_q) - 45'(syi_s2);
		b_s3    <= (26'(yj_s2) - 26'(yi_s2)) <<< 1;
		c_s3    <= 25'(xj_s2) - 25'(xi_s2);
		cond_s3 <= (44'(syi_s2) > py_q) != (44'(syj_s2) > py_q);
		dpos_s3 <= yj_s2 > yi_s2;
		// split the wide factors into high and low partial products
		pah_s4  <= $signed(a_s3[44:23]) * b_s3;
		pal_s4  <= $signed({1'b0, a_s3[22:0]}) * b_s3;
		pdh_s4  <= $signed(d_s3[44:23]) * c_s3;
		pdl_s4  <= $signed({1'b0, d_s3[22:0]}) * c_s3;
		cond_s4 <= cond_s3;
		dpos_s4 <= dpos_s3;
		lhs_s5  <= (72'(pah_s4) <<< 23) + 72'(pal_s4);
		rhs_s5  <= (72'(pdh_s4) <<< 23) + 72'(pdl_s4);
		cond_s5 <= cond_s4;
		dpos_s5 <= dpos_s4;
	end

endmodule

FILE: dv/polygon_layer_hit_test_test.sv
// Testbench for polygon_layer_hit_test: directed and random command streams,
// checked against an exact integer predictor of the layer table and ray cast.
// Depends on plht_pkg and the polygon_layer_hit_test RTL.
`timescale 1ns / 1ps

module polygon_layer_hit_test_test;
	import plht_pkg::*;

	typedef logic signed [127:0] wide_t;

	localparam int CYCLE_LIMIT = 3000000;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    done;
	result_t result;

	polygon_layer_hit_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// Shadow copy of the layer table
	int  vert_x [MAX_LAYERS][MAX_POINTS];
	int  vert_y [MAX_LAYERS][MAX_POINTS];
	int  vert_count [MAX_LAYERS];
	int  layer_vw [MAX_LAYERS];
	longint layer_w [MAX_LAYERS];
	longint layer_h [MAX_LAYERS];
	int  layers_used;
	bit  layer_open;

	result_t hits_pending [$];
	int      errors = 0;
	int      cycles = 0;
	int      idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Even-odd ray cast of one layer, exact: scale to integers and compare
	// cross products at 128 bits instead of dividing.
	function automatic bit poly_contains(int k, longint px, longint py);
		bit     inside_poly;
		int     n, i, j;
		longint xi, yi, xj, yj, d;
		wide_t  lhs, rhs;
		bit     crosses;
		n = vert_count[k];
		inside_poly = 1'b0;
		j = n - 1;
		for (i = 0; i < n; i++) begin
			xi = longint'(vert_x[k][i]) * 51200;
			yi = longint'(vert_y[k][i]) * 102400;
			xj = longint'(vert_x[k][j]) * 51200;
			yj = longint'(vert_y[k][j]) * 102400;
			if ((yi > py) != (yj > py)) begin
				d = yj - yi;
				lhs = wide_t'(px - xi) * wide_t'(d);
				rhs = wide_t'(xj - xi) * wide_t'(py - yi);
				crosses = (d > 0) ? (lhs < rhs) : (rhs < lhs);
				if (crosses)
					inside_poly = ~inside_poly;
			end
			j = i;
		end
		return inside_poly;
	endfunction

	// Advance the shadow table by one accepted item; queue the expected result on a query.
	task automatic apply_command(item_t it);
		int      k;
		longint  bx, by;
		result_t res;
		case (it.cmd)
			CMD_CLEAR: begin
				layers_used = 0;
				layer_open = 1'b0;
			end
			CMD_OPEN: begin
				if (layers_used < MAX_LAYERS) begin
					k = layers_used;
					layers_used++;
					vert_count[k] = 0;
					layer_vw[k] = it.view;
					layer_w[k] = $signed(it.view_width);
					layer_h[k] = $signed(it.view_height);
					layer_open = 1'b1;
				end else begin
					layer_open = 1'b0;
				end
			end
			CMD_APPEND: begin
				if (layer_open && layers_used > 0) begin
					k = layers_used - 1;
					if (vert_count[k] < MAX_POINTS) begin
						vert_x[k][vert_count[k]] = $signed(it.vertex_x);
						vert_y[k][vert_count[k]] = $signed(it.vertex_y);
						vert_count[k]++;
					end
				end
			end
			default: begin
				bx = $signed(it.body_x);
				by = $signed(it.body_y);
				res = '0;
				for (k = 0; k < layers_used; k++) begin
					if (layer_vw[k] == it.view && vert_count[k] >= MIN_VERTS
							&& layer_w[k] > 0 && layer_h[k] > 0
							&& poly_contains(k, bx * layer_w[k], by * layer_h[k])) begin
						res.hit = 1'b1;
						res.hit_layer = k[3:0];
						break;
					end
				end
				hits_pending.push_back(res);
			end
		endcase
	endtask

	// Hold start until the item is taken, then maybe drop start for a random gap.
	task automatic send_item(item_t it);
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy);
		apply_command(it);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic item_t make_item(cmd_t c);
		item_t it;
		it = '0;
		it.cmd = c;
		return it;
	endfunction

	task automatic send_clear();
		send_item(make_item(CMD_CLEAR));
	endtask

	task automatic send_open(int vw, int w, int h);
		item_t it;
		it = make_item(CMD_OPEN);
		it.view = vw[1:0];
		it.view_width = w[23:0];
		it.view_height = h[23:0];
		send_item(it);
	endtask

	task automatic send_vertex(int x, int y);
		item_t it;
		it = make_item(CMD_APPEND);
		it.vertex_x = x[23:0];
		it.vertex_y = y[23:0];
		send_item(it);
	endtask

	task automatic send_query(int vw, int bx, int by);
		item_t it;
		it = make_item(CMD_QUERY);
		it.view = vw[1:0];
		it.body_x = bx[19:0];
		it.body_y = by[19:0];
		send_item(it);
	endtask

	// Hold the sender until every expected result is back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (hits_pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// Results cannot be held off: check each strobe against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (hits_pending.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = hits_pending.pop_front();
				if (result.hit !== want.hit)
					report_mismatch("hit", result.hit, want.hit);
				if (result.hit_layer !== want.hit_layer)
					report_mismatch("hit_layer", result.hit_layer, want.hit_layer);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Empty table, one square, skipped layers, dropped appends, field extremes.
	task automatic test_directed();
		send_clear();
		send_query(0, 100 * 256, 200 * 256);
		send_vertex(5, 5);                       // no open layer: dropped
		send_open(1, 200 * 256, 400 * 256);      // square 50..150 x 100..300
		send_vertex(50 * 256, 100 * 256);
		send_vertex(150 * 256, 100 * 256);
		send_vertex(150 * 256, 300 * 256);
		send_vertex(50 * 256, 300 * 256);
		send_query(1, 100 * 256, 200 * 256);     // inside
		send_query(1, 10 * 256, 200 * 256);      // outside
		send_query(2, 100 * 256, 200 * 256);     // other view
		send_open(1, -8388608, 400 * 256);       // non-positive width
		send_vertex(-8388608, -8388608);
		send_vertex(8388607, -8388608);
		send_vertex(0, 8388607);
		send_open(1, 8388607, 8388607);          // only two vertices
		send_vertex(-8388608, 0);
		send_vertex(8388607, 0);
		send_query(1, -524288, 524287);
		send_query(1, 524287, -524288);
		send_query(3, 0, 0);
		send_clear();
		send_vertex(1, 1);                       // cleared: dropped
		send_query(1, 100 * 256, 200 * 256);
		drain();
	endtask

	// Fill the table, then open once more: the open fails and appends drop.
	task automatic test_layer_full();
		int k;
		send_clear();
		for (k = 0; k < MAX_LAYERS; k++) begin
			send_open(k % 4, 200 * 256, 400 * 256);
			send_vertex((k * 8) * 256, 0);
			send_vertex((k * 8 + 8) * 256, 0);
			send_vertex((k * 8 + 4) * 256, 400 * 256);
		end
		send_open(3, 200 * 256, 400 * 256);
		send_vertex(0, 0);
		send_query(3, 125 * 256, 10 * 256);      // last layer, view 3
		send_query(0, 4 * 256, 10 * 256);
		send_query(1, 199 * 256, 399 * 256);
		drain();
	endtask

	// One layer past its vertex limit: extra appends are dropped.
	task automatic test_point_full();
		int i;
		send_clear();
		send_open(0, 200 * 256, 400 * 256);
		for (i = 0; i < MAX_POINTS + 3; i++)
			send_vertex($urandom_range(0, 51200), $urandom_range(0, 102400));
		send_query(0, 100 * 256, 200 * 256);
		send_query(0, $urandom_range(0, 51200), $urandom_range(0, 102400));
		drain();
	endtask

	// Random layers with queries in the body box, plus raw noise items.
	task automatic test_random(int count, int pct);
		int           sent, n, i, w, h;
		item_t        it;
		logic [159:0] noise;
		idle_pct = pct;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(9))
				0: begin
					noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
					it = noise[$bits(item_t)-1:0];
					send_item(it);
					sent++;
				end
				1, 2, 3: begin
					if (layers_used >= MAX_LAYERS - 1 && $urandom_range(1)) begin
						send_clear();
						sent++;
					end
					w = ($urandom_range(7) == 0) ? -$urandom_range(0, 4096)
						: $urandom_range(256, 65535);
					h = $urandom_range(256, 131071);
					n = ($urandom_range(9) == 0) ? $urandom_range(9, 40)
						: $urandom_range(2, 8);
					send_open($urandom_range(1), w, h);
					for (i = 0; i < n; i++)
						send_vertex($urandom_range(0, (w > 0) ? w : 256),
							$urandom_range(0, h));
					sent += n + 1;
				end
				default: begin
					send_query($urandom_range(1), $urandom_range(0, 51200),
						$urandom_range(0, 102400));
					sent++;
				end
			endcase
		end
	endtask

	initial begin
		idle_pct = 0;
		layers_used = 0;
		layer_open = 1'b0;
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_layer_full();
		test_point_full();
		test_random(50, 0);
		test_random(45, 69);
		drain();
		test_random(45, 18);

		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/plht_pkg.sv
rtl/core/plht_front.sv
rtl/core/plht_back.sv
rtl/core/polygon_layer_hit_test.sv
dv/polygon_layer_hit_test_test.sv
